/* hdl/cfb_pkg.sv */
// Shared types and constants for the counting fingerprint bucket.
// Command and result payloads, queued job format, operation codes.
// No dependencies.
package cfb_pkg;

  localparam int SLOTS   = 4;
  localparam int FP_BITS = 15;
  localparam int ENTRY_W = FP_BITS + 1;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_REMOVE = 3'd1;
  localparam logic [2:0] KIND_COUNT  = 3'd2;
  localparam logic [2:0] KIND_SPLIT  = 3'd3;
  localparam logic [2:0] KIND_RAW    = 3'd4;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_COUNT,
    OP_SPLIT,
    OP_RAW,
    OP_NONE
  } op_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [14:0] fingerprint;
    logic [7:0]  insert_count;
    logic [3:0]  split_level;
    logic [15:0] raw_entry;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  remaining_count;
    logic        found;
    logic [14:0] removed_fingerprint;
    logic [3:0]  match_count;
    logic [15:0] moved_entry;
    logic        moved_valid;
    logic        stored_ok;
    logic        last;
  } res_t;

  typedef struct packed {
    op_e                op;
    logic [FP_BITS-1:0] fp;
    logic [7:0]         cnt;
    logic [ENTRY_W-1:0] split_mask;
    logic [ENTRY_W-1:0] raw;
  } job_t;

endpackage

/* hdl/counting_fingerprint_bucket.sv */
// Top level of the counting fingerprint bucket.
// Ties the command front end (cfb_front) to the slot engine (cfb_back).
// Depends on cfb_pkg, cfb_front, cfb_back.
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------
//  command  | start / busy        | cmd_i
//  result   | res_valid_o strobe  | res_o
//
// A command sits in a two-entry queue; the engine takes one job at a time,
// loads it, then works one slot per cycle, in a scan for remove, count, split
// and raw insert, or a bump scan then a fill scan for insert. Results are
// registered and appear in the cycle after the slot that settles them; split
// emits one per moved entry, or one final result if none moves. Reset empties
// every slot and the queue at once. busy rises only while the queue is full; results cannot be stalled.
module counting_fingerprint_bucket import cfb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmd_t cmd_i,
  output logic res_valid_o,
  output res_t res_o
);

  logic job_valid, job_pop;
  job_t job;

  cfb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  cfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

/* hdl/cfb_front.sv */
// Front end: accepts commands, decodes them into jobs and queues them.
// Depends on cfb_pkg.
module cfb_front import cfb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmd_t cmd_i,
  output logic job_valid_o,
  output job_t job_o,
  input  logic job_pop_i
);

  job_t               q_mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               push;
  job_t               job_new;

  always_comb begin
    job_new.fp  = FP_BITS'(cmd_i.fingerprint);
    job_new.cnt = cmd_i.insert_count;
    job_new.raw = ENTRY_W'(cmd_i.raw_entry);
    if (int'(cmd_i.split_level) < FP_BITS) begin
      job_new.split_mask = ENTRY_W'(1) << (cmd_i.split_level + 5'd1);
    end else begin
      job_new.split_mask = '0;
    end
    unique case (cmd_i.kind)
      KIND_INSERT: job_new.op = OP_INSERT;
      KIND_REMOVE: job_new.op = OP_REMOVE;
      KIND_COUNT:  job_new.op = OP_COUNT;
      KIND_SPLIT:  job_new.op = OP_SPLIT;
      KIND_RAW:    job_new.op = OP_RAW;
      default:     job_new.op = OP_NONE;
    endcase
  end

  assign busy        = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign push        = start && !busy;
  assign job_valid_o = (cnt_q != '0);
  assign job_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (int'(wr_ptr_q) == Q_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (job_pop_i && job_valid_o) begin
      rd_ptr_d = (int'(rd_ptr_q) == Q_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    priority if (push && !(job_pop_i && job_valid_o)) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && job_pop_i && job_valid_o) begin
      cnt_d = cnt_q - 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= job_new;
    end
  end

endmodule

/* hdl/cfb_back.sv */
// Back end: holds the slot store and runs each job one slot per cycle.
// Depends on cfb_pkg; fed by cfb_front.
module cfb_back import cfb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  input  job_t job_i,
  output logic job_pop_o,
  output logic res_valid_o,
  output res_t res_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FILL = 2'd2;

  logic [1:0]         st_q, st_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  job_t               job_q, job_d;
  logic [7:0]         cnt_q, cnt_d;
  logic               flag_q, flag_d;
  logic [FP_BITS-1:0] rfp_q, rfp_d;
  logic [3:0]         sum_q, sum_d;
  logic [ENTRY_W-1:0] slot_q [SLOTS];
  logic [ENTRY_W-1:0] slot_d [SLOTS];
  res_t               res_q, res_d;
  logic               res_valid_q, res_valid_d;

  logic [ENTRY_W-1:0] e;
  logic               match, last_idx, move_now, later_any;
  logic [4:0]         sum_ext;

  assign e        = slot_q[idx_q];
  assign match    = (e != '0) && (e[ENTRY_W-1:1] == job_q.fp);
  assign last_idx = (idx_q == IDX_W'(SLOTS - 1));
  assign move_now = ((e & job_q.split_mask) != '0);
  assign sum_ext  = {1'b0, sum_q} + (match ? (e[0] ? 5'd2 : 5'd1) : 5'd0);

  always_comb begin
    later_any = 1'b0;
    for (int j = 0; j < SLOTS; j++) begin
      if ((j > int'(idx_q)) && ((slot_q[j] & job_q.split_mask) != '0)) begin
        later_any = 1'b1;
      end
    end
  end

  always_comb begin
    st_d        = st_q;
    idx_d       = idx_q;
    job_d       = job_q;
    cnt_d       = cnt_q;
    flag_d      = flag_q;
    rfp_d       = rfp_q;
    sum_d       = sum_q;
    slot_d      = slot_q;
    res_d       = '0;
    res_valid_d = 1'b0;
    job_pop_o   = 1'b0;

    unique case (st_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          cnt_d     = job_i.cnt;
          flag_d    = 1'b0;
          rfp_d     = '0;
          sum_d     = '0;
          idx_d     = '0;
          st_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        unique case (job_q.op)
          OP_INSERT: begin
            if (job_q.fp != '0 && cnt_q != '0 && match && !e[0]) begin
              slot_d[idx_q] = e | ENTRY_W'(1);
              cnt_d         = cnt_q - 8'd1;
            end
          end
          OP_REMOVE: begin
            if (!flag_q && match) begin
              flag_d        = 1'b1;
              rfp_d         = e[ENTRY_W-1:1];
              slot_d[idx_q] = e[0] ? {e[ENTRY_W-1:1], 1'b0} : '0;
            end
          end
          OP_COUNT: begin
            sum_d = sum_ext[4] ? 4'hF : sum_ext[3:0];
          end
          OP_SPLIT: begin
            if (move_now) begin
              slot_d[idx_q]     = '0;
              flag_d            = 1'b1;
              res_valid_d       = 1'b1;
              res_d.moved_entry = 16'(e);
              res_d.moved_valid = 1'b1;
              res_d.last        = !later_any;
            end else if (last_idx && !flag_q) begin
              res_valid_d = 1'b1;
              res_d.last  = 1'b1;
            end
          end
          OP_RAW: begin
            if (!flag_q && e == '0) begin
              slot_d[idx_q] = job_q.raw;
              flag_d        = 1'b1;
            end
          end
          default: begin
          end
        endcase
        if (last_idx) begin
          idx_d = '0;
          if (job_q.op == OP_INSERT) begin
            st_d = S_FILL;
          end else begin
            st_d = S_IDLE;
            if (job_q.op != OP_SPLIT) begin
              res_valid_d               = 1'b1;
              res_d.last                = 1'b1;
              res_d.found               = (job_q.op == OP_REMOVE) && flag_d;
              res_d.removed_fingerprint = 15'(rfp_d);
              res_d.match_count         = sum_d;
              res_d.stored_ok           = (job_q.op == OP_RAW) && flag_d;
            end
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_FILL: begin
        if (job_q.fp != '0 && cnt_q != '0 && e == '0) begin
          if (cnt_q != 8'd1) begin
            slot_d[idx_q] = {job_q.fp, 1'b1};
            cnt_d         = cnt_q - 8'd2;
          end else begin
            slot_d[idx_q] = {job_q.fp, 1'b0};
            cnt_d         = '0;
          end
        end
        if (last_idx) begin
          idx_d                 = '0;
          st_d                  = S_IDLE;
          res_valid_d           = 1'b1;
          res_d.last            = 1'b1;
          res_d.remaining_count = cnt_d;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      idx_q       <= '0;
      flag_q      <= 1'b0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_q[i] <= '0;
      end
    end else begin
      st_q        <= st_d;
      idx_q       <= idx_d;
      flag_q      <= flag_d;
      res_valid_q <= res_valid_d;
      slot_q      <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    cnt_q <= cnt_d;
    rfp_q <= rfp_d;
    sum_q <= sum_d;
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef ASSERT_OFF
  a_last_ends_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.last && job_q.op != OP_SPLIT |-> st_q == S_IDLE)
    else $error("final result while job still running");
  a_partial_only_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_q.last |-> job_q.op == OP_SPLIT && st_q == S_SCAN)
    else $error("non-final result outside split scan");
  a_moved_only_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.moved_valid |-> job_q.op == OP_SPLIT)
    else $error("moved entry reported by non-split job");
  a_pop_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> st_q == S_SCAN && idx_q == '0)
    else $error("popped job did not start scan");
`endif

endmodule
